[rtl/sgm_pkg.sv]
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants of the Sobel gradient magnitude block
// Frame geometry limits, register indexes and the request and result types.
// ----------------------------------------------------------------------------
package sgm_pkg;

  // Frame geometry
  localparam int MAX_WIDTH    = 2048;
  localparam int COL_AW       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W      = 12;
  localparam int HEIGHT_W     = 16;
  localparam int POS_W        = 27;
  localparam int PIX_W        = 8;
  localparam int DIV_CNT_W    = $clog2(POS_W + 1);

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Window queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_magnitude;
    logic             frame_last;
  } out_item_t;

  // 3x3 window with out-of-frame pixels already zeroed, index row*3+col
  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    logic                  frame_last;
  } win_item_t;

endpackage

[rtl/sgm_ram.sv]
// ----------------------------------------------------------------------------
// sgm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sgm_fifo.sv]
// ----------------------------------------------------------------------------
// sgm_fifo: short window queue between front and back
// Holds masked 3x3 windows; the front reserves space before it accepts.
// ----------------------------------------------------------------------------
module sgm_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  sgm_pkg::win_item_t               data_i,
  input  logic                             pop_i,
  output logic                             valid_o,
  output sgm_pkg::win_item_t               data_o,
  output logic [sgm_pkg::FIFO_CNT_W-1:0]   cnt_o
);

  sgm_pkg::win_item_t                 mem_q [sgm_pkg::FIFO_DEPTH];
  logic [sgm_pkg::FIFO_AW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [sgm_pkg::FIFO_AW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [sgm_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;

  localparam logic [sgm_pkg::FIFO_AW-1:0] LastPtr = sgm_pkg::FIFO_AW'(sgm_pkg::FIFO_DEPTH - 1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + sgm_pkg::FIFO_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + sgm_pkg::FIFO_AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + sgm_pkg::FIFO_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - sgm_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

endmodule

[rtl/sgm_front.sv]
// ----------------------------------------------------------------------------
// sgm_front: request intake, line stores and window
// Tracks the raster position, reads and updates the two line stores, slides
// the 3x3 window, classifies border pixels and queues masked windows.
// A configuration write reloads the output column/row by a bit-serial divide.
// ----------------------------------------------------------------------------
module sgm_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               push_i,
  input  sgm_pkg::in_item_t                  item_i,
  input  logic [sgm_pkg::FIFO_CNT_W-1:0]     fifo_cnt_i,
  output logic                               full_o,
  output logic                               busy_o,
  output logic                               win_vld_o,
  output sgm_pkg::win_item_t                 win_o
);

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  localparam int W  = sgm_pkg::WIDTH_W;
  localparam int HW = sgm_pkg::HEIGHT_W;
  localparam int PW = sgm_pkg::POS_W;
  localparam int AW = sgm_pkg::COL_AW;
  localparam int XW = sgm_pkg::PIX_W;
  localparam int CW = sgm_pkg::FIFO_CNT_W;

  // Configuration and position state
  state_e                            state_q, state_d;
  logic [W-1:0]                      width_q, width_d;
  logic [HW-1:0]                     height_q, height_d;
  logic [W-1:0]                      col_q, col_d;
  logic [1:0]                        row_q, row_d;
  logic [PW-1:0]                     op_q, op_d;
  logic [PW-1:0]                     cr_q, cr_d;
  logic [W-1:0]                      cc_q, cc_d;
  logic [sgm_pkg::DIV_CNT_W-1:0]     div_cnt_q, div_cnt_d;
  logic [PW-1:0]                     area_q;

  // Stage 1
  logic                              s1_vld_q;
  logic                              s1_has_q;
  border_t                           s1_bdr_q;
  logic                              s1_last_q;
  logic [XW-1:0]                     s1_pix_q;
  logic [AW-1:0]                     s1_addr_q;
  logic                              s1_fwd_q;
  logic [XW-1:0]                     fwd_up_q, fwd_lo_q;
  logic [8:0][XW-1:0]                win_q, win_d;

  logic [W-1:0]                      w_eff;
  logic [HW-1:0]                     h_eff;
  logic [W+HW-1:0]                   area_full;
  logic                              accept;
  logic                              wrap;
  logic [W-1:0]                      col_use;
  logic [1:0]                        row_use;
  logic                              has_res;
  logic                              last;
  border_t                           bdr;
  logic [AW-1:0]                     rd_addr;
  logic [XW-1:0]                     pix_in;
  logic [W:0]                        div_sh;
  logic                              div_ge;
  logic [W:0]                        div_rem;
  logic [XW-1:0]                     up_rd, lo_rd, up_eff, lo_eff;

  // Effective geometry
  always_comb begin
    if (width_q == '0) begin
      w_eff = W'(1);
    end else if (32'(width_q) > sgm_pkg::MAX_WIDTH) begin
      w_eff = W'(sgm_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? HW'(1) : height_q;
  end

  assign area_full = (W + HW)'(w_eff) * (W + HW)'(h_eff);

  // Hold off requests while dividing and while the queue has no room left
  assign busy_o = (state_q == ST_DIV);
  assign full_o = busy_o ||
                  ((CW + 1)'(fifo_cnt_i) + (CW + 1)'(s1_vld_q) >=
                   (CW + 1)'(sgm_pkg::FIFO_DEPTH));
  assign accept = push_i && !full_o;

  // Raster position of the incoming request
  assign wrap    = (col_q >= w_eff);
  assign col_use = wrap ? '0 : col_q;
  assign row_use = wrap ? ((row_q == 2'd2) ? 2'd2 : row_q + 2'd1) : row_q;
  // No result until the stream is one row and one pixel ahead
  assign has_res = (row_use == 2'd2) || ((row_use == 2'd1) && (col_use != '0));
  assign rd_addr = col_use[AW-1:0];
  assign pix_in  = (item_i.command == sgm_pkg::CMD_FLUSH) ? '0 : item_i.pixel_value;

  // Border classification of the output pixel
  assign bdr.top    = (cr_q == '0);
  assign bdr.bottom = ((PW + 1)'(cr_q) + (PW + 1)'(1) >= (PW + 1)'(h_eff));
  assign bdr.left   = (cc_q == '0);
  assign bdr.right  = ((W + 1)'(cc_q) + (W + 1)'(1) >= (W + 1)'(w_eff));
  assign last       = ((PW + 1)'(op_q) + (PW + 1)'(1) >= (PW + 1)'(area_q));

  // Restoring divide: cr_q shifts quotient bits in, cc_q keeps the remainder
  assign div_sh  = {cc_q, cr_q[PW-1]};
  assign div_ge  = (div_sh >= (W + 1)'(w_eff));
  assign div_rem = div_ge ? div_sh - (W + 1)'(w_eff) : div_sh;

  always_comb begin
    state_d   = state_q;
    width_d   = width_q;
    height_d  = height_q;
    col_d     = col_q;
    row_d     = row_q;
    op_d      = op_q;
    cr_d      = cr_q;
    cc_d      = cc_q;
    div_cnt_d = div_cnt_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == sgm_pkg::REG_IMAGE_WIDTH) begin
        width_d = cfg_data_i[W-1:0];
      end else if (cfg_idx_i == sgm_pkg::REG_IMAGE_HEIGHT) begin
        height_d = cfg_data_i[HW-1:0];
      end
      // Rebuild column and row of the output position under the new width
      state_d   = ST_DIV;
      div_cnt_d = sgm_pkg::DIV_CNT_W'(PW);
      cr_d      = op_q;
      cc_d      = '0;
    end else if (state_q == ST_DIV) begin
      cr_d      = {cr_q[PW-2:0], div_ge};
      cc_d      = div_rem[W-1:0];
      div_cnt_d = div_cnt_q - sgm_pkg::DIV_CNT_W'(1);
      if (div_cnt_q == sgm_pkg::DIV_CNT_W'(1)) begin
        state_d = ST_RUN;
      end
    end else if (accept) begin
      if (has_res && last) begin
        col_d = '0;
        row_d = '0;
        op_d  = '0;
        cr_d  = '0;
        cc_d  = '0;
      end else begin
        col_d = col_use + W'(1);
        row_d = row_use;
        if (has_res) begin
          op_d = op_q + PW'(1);
          if (bdr.right) begin
            cc_d = '0;
            cr_d = cr_q + PW'(1);
          end else begin
            cc_d = cc_q + W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      width_q   <= W'(sgm_pkg::WIDTH_RESET);
      height_q  <= HW'(sgm_pkg::HEIGHT_RESET);
      col_q     <= '0;
      row_q     <= '0;
      op_q      <= '0;
      cr_q      <= '0;
      cc_q      <= '0;
      div_cnt_q <= '0;
      area_q    <= PW'(sgm_pkg::WIDTH_RESET * sgm_pkg::HEIGHT_RESET);
      s1_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      width_q   <= width_d;
      height_q  <= height_d;
      col_q     <= col_d;
      row_q     <= row_d;
      op_q      <= op_d;
      cr_q      <= cr_d;
      cc_q      <= cc_d;
      div_cnt_q <= div_cnt_d;
      area_q    <= area_full[PW-1:0];
      s1_vld_q  <= accept;
    end
  end

  // Line stores
  sgm_ram #(
    .WIDTH(XW),
    .DEPTH(sgm_pkg::MAX_WIDTH)
  ) u_ram_upper (
    .clk_i  (clk_i),
    .we_i   (s1_vld_q),
    .waddr_i(s1_addr_q),
    .wdata_i(lo_eff),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(up_rd)
  );

  sgm_ram #(
    .WIDTH(XW),
    .DEPTH(sgm_pkg::MAX_WIDTH)
  ) u_ram_lower (
    .clk_i  (clk_i),
    .we_i   (s1_vld_q),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_pix_q),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(lo_rd)
  );

  // Forward the previous request's writes when it hit the same column
  assign up_eff = s1_fwd_q ? fwd_up_q : up_rd;
  assign lo_eff = s1_fwd_q ? fwd_lo_q : lo_rd;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = up_eff;
    win_d[5] = lo_eff;
    win_d[8] = s1_pix_q;
  end

  always_comb begin
    win_o.frame_last = s1_last_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && s1_bdr_q.top) || (r == 2 && s1_bdr_q.bottom) ||
            (c == 0 && s1_bdr_q.left) || (c == 2 && s1_bdr_q.right)) begin
          win_o.pix[r*3 + c] = '0;
        end else begin
          win_o.pix[r*3 + c] = win_d[r*3 + c];
        end
      end
    end
  end

  assign win_vld_o = s1_vld_q && s1_has_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_vld_q) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_has_q  <= has_res;
      s1_bdr_q  <= bdr;
      s1_last_q <= last;
      s1_pix_q  <= pix_in;
      s1_addr_q <= rd_addr;
      s1_fwd_q  <= s1_vld_q && (s1_addr_q == rd_addr);
    end
    if (s1_vld_q) begin
      fwd_up_q <= lo_eff;
      fwd_lo_q <= s1_pix_q;
    end
  end

endmodule

[rtl/sgm_back.sv]
// ----------------------------------------------------------------------------
// sgm_back: gradient and magnitude pipeline
// Pops masked windows, forms gx and gy, squares them, takes an exact
// integer square root two digits per stage and saturates to 8 bits.
// ----------------------------------------------------------------------------
module sgm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 win_vld_i,
  input  sgm_pkg::win_item_t   win_i,
  output logic                 win_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output sgm_pkg::out_item_t   out_item_o
);

  localparam int XW = sgm_pkg::PIX_W;
  localparam int NS = 4;

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        sat;
    logic [15:0] rem;
    logic [15:0] root;
  } sq_t;

  function automatic sq_t sq_step(input sq_t x, input int k);
    logic [15:0] b;
    logic [16:0] t;
    sq_t         y;
    b = 16'(1) << (14 - 2 * k);
    t = {1'b0, x.root} + {1'b0, b};
    y = x;
    if ({1'b0, x.rem} >= t) begin
      y.rem  = x.rem - t[15:0];
      y.root = (x.root >> 1) + b;
    end else begin
      y.root = x.root >> 1;
    end
    return y;
  endfunction

  logic                 en;
  logic                 a_vld_q, a_last_q;
  logic signed [10:0]   gx_q, gy_q, gx_d, gy_d;
  logic                 b_vld_q, b_last_q;
  logic [19:0]          sqx_q, sqy_q;
  logic signed [21:0]   sqx_full, sqy_full;
  logic [20:0]          sum;
  sq_t                  sq_q [NS + 1];
  sq_t                  sq_d [NS + 1];
  logic                 out_vld_q;
  sgm_pkg::out_item_t   out_q;
  logic [9:0]           gx_pos, gx_neg, gy_pos, gy_neg;

  // Advance everything unless a finished result is still waiting
  assign en        = !out_vld_q || pop;
  assign win_pop_o = en && win_vld_i;

  always_comb begin
    gx_pos = 10'(win_i.pix[2]) + {1'b0, win_i.pix[5], 1'b0} + 10'(win_i.pix[8]);
    gx_neg = 10'(win_i.pix[0]) + {1'b0, win_i.pix[3], 1'b0} + 10'(win_i.pix[6]);
    gy_pos = 10'(win_i.pix[0]) + {1'b0, win_i.pix[1], 1'b0} + 10'(win_i.pix[2]);
    gy_neg = 10'(win_i.pix[6]) + {1'b0, win_i.pix[7], 1'b0} + 10'(win_i.pix[8]);
    gx_d   = signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
    gy_d   = signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});
  end

  assign sqx_full = gx_q * gx_q;
  assign sqy_full = gy_q * gy_q;
  assign sum      = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    sq_d[0].vld  = b_vld_q;
    sq_d[0].last = b_last_q;
    sq_d[0].sat  = |sum[20:16];
    sq_d[0].rem  = sum[15:0];
    sq_d[0].root = '0;
    for (int s = 0; s < NS; s++) begin
      sq_d[s + 1] = sq_step(sq_step(sq_q[s], 2 * s), 2 * s + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int s = 0; s <= NS; s++) begin
        sq_q[s] <= '0;
      end
    end else if (en) begin
      a_vld_q   <= win_vld_i;
      b_vld_q   <= a_vld_q;
      out_vld_q <= sq_q[NS].vld;
      for (int s = 0; s <= NS; s++) begin
        sq_q[s] <= sq_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_last_q <= win_i.frame_last;
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      b_last_q <= a_last_q;
      sqx_q    <= sqx_full[19:0];
      sqy_q    <= sqy_full[19:0];
      out_q.edge_magnitude <= sq_q[NS].sat ? {XW{1'b1}} : sq_q[NS].root[XW-1:0];
      out_q.frame_last     <= sq_q[NS].last;
    end
  end

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

endmodule

[rtl/sobel_gradient_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude: streaming 3x3 Sobel edge magnitude
// Raster pixels in, saturated floor(sqrt(gx^2+gy^2)) out, one row plus one
// pixel behind the input, with the frame's final result flagged.
//
//   channel  handshake          payload
//   input    push / full        in_item_i  (command, pixel_value)
//   result   empty / pop        out_item_o (edge_magnitude, frame_last)
//   config   cfg_we_i           cfg_idx_i, cfg_data_i (0 width, 1 height)
//
// One request per clock while full is low; a result passes the gradient,
// square, root and output registers of the back pipeline after its window
// is queued. Each configuration write raises full while the divider maps
// the output position to column and row under the new width, one quotient
// bit per cycle. Reset clears counters and window; the line stores are not
// cleared. A held result stalls the back pipeline, and the front keeps
// taking requests until the 4-entry window queue is committed.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  sgm_pkg::in_item_t                  in_item_i,
  output logic                               empty,
  input  logic                               pop,
  output sgm_pkg::out_item_t                 out_item_o
);

  logic                              busy;
  logic                              win_vld;
  sgm_pkg::win_item_t                win_push;
  logic                              fifo_vld;
  sgm_pkg::win_item_t                fifo_data;
  logic                              fifo_pop;
  logic [sgm_pkg::FIFO_CNT_W-1:0]    fifo_cnt;

  sgm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push_i    (push),
    .item_i    (in_item_i),
    .fifo_cnt_i(fifo_cnt),
    .full_o    (full),
    .busy_o    (busy),
    .win_vld_o (win_vld),
    .win_o     (win_push)
  );

  sgm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (win_vld),
    .data_i (win_push),
    .pop_i  (fifo_pop),
    .valid_o(fifo_vld),
    .data_o (fifo_data),
    .cnt_o  (fifo_cnt)
  );

  sgm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .win_vld_i (fifo_vld),
    .win_i     (fifo_data),
    .win_pop_o (fifo_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  // A configuration write holds off requests while the divider runs
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (busy && full))
    else $error("request window open right after a configuration write");

  // Space is reserved before a request is taken, so the queue never overflows
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(win_vld && !fifo_pop && (fifo_cnt == sgm_pkg::FIFO_CNT_W'(sgm_pkg::FIFO_DEPTH))))
    else $error("window queue overflow");

  // The back only pops a queue that holds a window
  a_fifo_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> fifo_vld)
    else $error("window queue underflow");

  // While dividing, no window is produced
  a_no_push_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !win_vld)
    else $error("window queued during position rebuild");

endmodule

[tb/sv/sgm_edge_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgm_edge_checker: result checker for the Sobel gradient magnitude block
// Tracks register writes and accepted requests, predicts the saturated edge
// magnitude and frame end flag of each result, and compares every popped
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sgm_edge_checker
  import sgm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  input  logic                  full,
  input  in_item_t              req_i,
  input  logic                  empty,
  input  logic                  pop,
  input  out_item_t             res_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]    upper_line [MAX_WIDTH];
  logic [PIX_W-1:0]    lower_line [MAX_WIDTH];
  logic [PIX_W-1:0]    win [9];
  int unsigned         col_cnt;
  int unsigned         row_cnt;
  logic [POS_W-1:0]    out_pos;
  out_item_t           magnitude_q [$];
  int                  mismatches;

  function automatic int unsigned isqrt(input int unsigned radicand);
    int unsigned rem;
    int unsigned root;
    int unsigned probe;
    rem   = radicand;
    root  = 0;
    probe = 32'h4000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  task automatic predict_edge_magnitude(input in_item_t req);
    int unsigned     w;
    int unsigned     h;
    int unsigned     cr;
    int unsigned     cc;
    int unsigned     mag;
    longint unsigned pos;
    logic [PIX_W-1:0] v;
    int              tap [9];
    int              gx;
    int              gy;
    int              r;
    int              c;
    bit              off;
    bit              last;
    out_item_t       expected;

    if (width_reg == '0) begin
      w = 1;
    end else if (width_reg > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end else begin
      w = width_reg;
    end
    h = (height_reg == '0) ? 1 : height_reg;
    v = (req.command == CMD_FLUSH) ? '0 : req.pixel_value;

    // a column past the current width wraps to the next row
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    pos = longint'(row_cnt) * w + col_cnt;

    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = upper_line[col_cnt];
    win[5] = lower_line[col_cnt];
    win[8] = v;
    upper_line[col_cnt] = lower_line[col_cnt];
    lower_line[col_cnt] = v;
    col_cnt++;

    // no result until one row plus one pixel is in
    if (pos < w + 1) return;

    cr = out_pos / w;
    cc = out_pos % w;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        off = (r == 0 && cr == 0) || (r == 2 && cr + 1 >= h) ||
              (c == 0 && cc == 0) || (c == 2 && cc + 1 >= w);
        tap[r*3+c] = off ? 0 : int'(win[r*3+c]);
      end
    end
    gx  = (tap[2] + 2 * tap[5] + tap[8]) - (tap[0] + 2 * tap[3] + tap[6]);
    gy  = (tap[0] + 2 * tap[1] + tap[2]) - (tap[6] + 2 * tap[7] + tap[8]);
    mag = isqrt(gx * gx + gy * gy);
    if (mag > 255) mag = 255;
    last = (longint'(out_pos) + 1 >= longint'(w) * h);

    expected.edge_magnitude = PIX_W'(mag);
    expected.frame_last     = last;
    magnitude_q.push_back(expected);

    if (last) begin
      col_cnt = 0;
      row_cnt = 0;
      out_pos = '0;
    end else begin
      out_pos = out_pos + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t expected;
    if (!rst_ni) begin
      width_reg  = WIDTH_W'(WIDTH_RESET);
      height_reg = HEIGHT_W'(HEIGHT_RESET);
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      out_pos    = '0;
      mismatches = 0;
      magnitude_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // the popped result left an earlier request, so check before predicting
      if (pop && !empty) begin
        if (magnitude_q.size() == 0) begin
          $error("result popped with no request pending: edge_magnitude %0d, frame_last %0d",
                 res_i.edge_magnitude, res_i.frame_last);
          mismatches++;
        end else begin
          expected = magnitude_q.pop_front();
          if (res_i.edge_magnitude !== expected.edge_magnitude) begin
            $error("edge_magnitude: expected %0d, actual %0d",
                   expected.edge_magnitude, res_i.edge_magnitude);
            mismatches++;
          end
          if (res_i.frame_last !== expected.frame_last) begin
            $error("frame_last: expected %0d, actual %0d",
                   expected.frame_last, res_i.frame_last);
            mismatches++;
          end
        end
      end
      if (push && !full) predict_edge_magnitude(req_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IMAGE_WIDTH) begin
          width_reg = cfg_data_i[WIDTH_W-1:0];
        end else begin
          height_reg = cfg_data_i[HEIGHT_W-1:0];
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= magnitude_q.size();
    end
  end

endmodule

[tb/sv/sobel_gradient_magnitude_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_test: stimulus and verdict for the edge block
// Writes frame geometries, streams directed and random frames with flush
// steps, idles and stalls both queue sides, and reports the checker's count.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_test;
  import sgm_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push     = 1'b0;
  logic                  full;
  in_item_t              in_item  = '0;
  logic                  empty;
  logic                  pop      = 1'b0;
  out_item_t             out_item;

  int fail_count;
  int pending;
  int tx_idle_pct    = 11;
  int rx_idle_pct    = 60;
  int stall_requests = 0;
  int stall_served   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int items_sent     = 0;

  sobel_gradient_magnitude DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  sgm_edge_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .req_i        (in_item),
    .empty        (empty),
    .pop          (pop),
    .res_i        (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  // result side: random pops, or a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      hold_left    <= HOLD_CYCLES;
      pop          <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("sobel_gradient_magnitude test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // offer one request until it is taken; random gaps ahead of it
  task automatic send_request(input cmd_e cmd, input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{command: cmd, pixel_value: px};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  // stop sending, wait out every pending result and the pipeline tail
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_frame(input int unsigned w, input int unsigned h);
    repeat (w * h) begin
      if ($urandom_range(99) < 5) send_request(CMD_FLUSH, PIX_W'($urandom));
      else send_request(CMD_PIXEL, random_pixel());
    end
    // drain the last row plus one; some stray pixels past the frame end
    repeat (w + 1) begin
      if ($urandom_range(99) < 30) send_request(CMD_PIXEL, random_pixel());
      else send_request(CMD_FLUSH, PIX_W'($urandom));
    end
  endtask

  initial begin
    logic [PIX_W-1:0] edge_frame [9];
    int unsigned w_reg;
    int unsigned h_reg;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned random_start;
    int unsigned phase;
    int unsigned last_phase;

    edge_frame = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 frame with a hard vertical edge: saturates in the middle;
    // a flush inside the frame counts as a zero pixel and drops its value
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 6) send_request(CMD_FLUSH, 8'hFF);
      else send_request(CMD_PIXEL, edge_frame[i]);
    end
    send_request(CMD_FLUSH, 8'h00);
    send_request(CMD_PIXEL, 8'hAA);
    send_request(CMD_FLUSH, 8'h55);
    send_request(CMD_FLUSH, 8'h00);

    // zero width and height fall back to a single pixel
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    send_request(CMD_PIXEL, 8'h80);
    send_request(CMD_PIXEL, 8'h7F);
    send_request(CMD_FLUSH, 8'h00);

    // width shrinks mid-frame: the column wraps into the next row
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd8);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    repeat (5) send_request(CMD_PIXEL, random_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    repeat (3 * 2 + 1) send_request(CMD_PIXEL, random_pixel());

    // tallest frame, cut short by lowering the height below the position
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'hA002);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    repeat (6) send_request(CMD_PIXEL, random_pixel());
    settle();
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    send_request(CMD_PIXEL, random_pixel());

    random_start = items_sent;
    last_phase   = 3;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      phase = (items_sent - random_start) * 3 / RANDOM_ITEMS;
      settle();
      if (phase != last_phase) begin
        last_phase  = phase;
        tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 60 : 0;
        rx_idle_pct    <= (phase == 0) ? 60 : (phase == 1) ? 11 : 0;
        stall_requests <= stall_requests + 1;
        if (phase == 2) begin
          // a gapless frame while the result side holds off fills the block
          write_reg(REG_IMAGE_WIDTH, 16'd16);
          write_reg(REG_IMAGE_HEIGHT, 16'd4);
          run_frame(16, 4);
          settle();
        end
      end
      case ($urandom_range(7))
        0:       w_reg = 0;
        1:       w_reg = $urandom_range(11, 40);
        default: w_reg = $urandom_range(1, 10);
      endcase
      h_reg = $urandom_range(0, 6);
      w_eff = (w_reg == 0) ? 1 : w_reg;
      h_eff = (h_reg == 0) ? 1 : h_reg;
      write_reg(REG_IMAGE_WIDTH, {4'($urandom), 12'(w_reg)});
      write_reg(REG_IMAGE_HEIGHT, 16'(h_reg));
      repeat ($urandom_range(1, 3)) run_frame(w_eff, h_eff);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("sobel_gradient_magnitude test passed");
    end else begin
      $display("sobel_gradient_magnitude test failed");
    end
    $finish;
  end

endmodule
